### rtl/core/rmq_pkg.sv
// Shared types and constants of the rotation matrix to quaternion pipeline.
`default_nettype none
package rmq_pkg;
    localparam int FRAC_BITS = 14;
    localparam int ELEM_W    = 16;
    localparam int OUT_W     = 16;
    localparam int RAD_W     = ((FRAC_BITS + 1 > ELEM_W) ? FRAC_BITS + 1 : ELEM_W) + 2;
    localparam int NUM_W     = ELEM_W + 1;
    localparam int SQ_IN_W   = RAD_W - 1 + FRAC_BITS + 2;
    localparam int SQ_PAD    = SQ_IN_W + (SQ_IN_W % 2);
    localparam int S_W       = SQ_PAD / 2;
    localparam int DIV_W     = NUM_W + FRAC_BITS + 1;
    localparam int NSTAGE    = S_W + DIV_W + 3;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } t_branch;

    typedef struct packed {
        t_branch                    br;
        logic                       inv;
        logic [2:0]                 neg;
        logic [2:0][NUM_W-1:0]      mag;
    } t_side;

    typedef struct packed {
        t_side                      side;
        logic [SQ_PAD-1:0]          rad;
        logic [S_W-1:0]             root;
        logic [S_W:0]               rem;
    } t_sq;

    typedef struct packed {
        t_branch                    br;
        logic                       inv;
        logic [2:0]                 neg;
        logic [S_W-1:0]             s;
        logic [S_W-1:0]             main;
        logic [2:0][DIV_W-1:0]      dvd;
        logic [2:0][S_W-1:0]        rem;
    } t_dv;
endpackage
`default_nettype wire

### rtl/core/rmq_front.sv
// Branch choice, radicand and numerators of one matrix.
`default_nettype none
module rmq_front import rmq_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic signed [ELEM_W-1:0] i_a00,
    input  wire logic signed [ELEM_W-1:0] i_a01,
    input  wire logic signed [ELEM_W-1:0] i_a02,
    input  wire logic signed [ELEM_W-1:0] i_a10,
    input  wire logic signed [ELEM_W-1:0] i_a11,
    input  wire logic signed [ELEM_W-1:0] i_a12,
    input  wire logic signed [ELEM_W-1:0] i_a20,
    input  wire logic signed [ELEM_W-1:0] i_a21,
    input  wire logic signed [ELEM_W-1:0] i_a22,
    output t_sq                           o_sq
);
    localparam logic signed [RAD_W-1:0] ONE = RAD_W'(1) <<< FRAC_BITS;

    logic signed [RAD_W-1:0] a00, a11, a22, tr, rad;
    logic signed [NUM_W-1:0] n0, n1, n2;
    logic signed [NUM_W-1:0] e01, e02, e10, e12, e20, e21;
    logic [2:0][NUM_W-1:0]   nv;
    t_branch                 br;
    logic                    inv;
    t_sq                     r_sq, n_sq;

    always_comb begin
        a00 = RAD_W'(i_a00);
        a11 = RAD_W'(i_a11);
        a22 = RAD_W'(i_a22);
        e01 = NUM_W'(i_a01);
        e02 = NUM_W'(i_a02);
        e10 = NUM_W'(i_a10);
        e12 = NUM_W'(i_a12);
        e20 = NUM_W'(i_a20);
        e21 = NUM_W'(i_a21);
        tr  = a00 + a11 + a22;
        if (tr > 0) begin
            br  = BR_TRACE;
            rad = tr + ONE;
            n0  = e21 - e12;
            n1  = e02 - e20;
            n2  = e10 - e01;
        end else if (i_a00 > i_a11 && i_a00 > i_a22) begin
            br  = BR_X;
            rad = ONE + a00 - a11 - a22;
            n0  = e21 - e12;
            n1  = e01 + e10;
            n2  = e02 + e20;
        end else if (i_a11 > i_a22) begin
            br  = BR_Y;
            rad = ONE + a11 - a00 - a22;
            n0  = e02 - e20;
            n1  = e01 + e10;
            n2  = e12 + e21;
        end else begin
            br  = BR_Z;
            rad = ONE + a22 - a00 - a11;
            n0  = e10 - e01;
            n1  = e02 + e20;
            n2  = e12 + e21;
        end
        inv = (rad <= 0);
        nv  = {n2, n1, n0};
        n_sq.side.br  = br;
        n_sq.side.inv = inv;
        for (int k = 0; k < 3; k++) begin
            n_sq.side.neg[k] = nv[k][NUM_W-1];
            n_sq.side.mag[k] = nv[k][NUM_W-1] ? NUM_W'(-nv[k]) : nv[k];
        end
        n_sq.rad  = inv ? '0
                  : SQ_PAD'({rad[RAD_W-2:0], (FRAC_BITS + 2)'(0)});
        n_sq.root = '0;
        n_sq.rem  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;
endmodule
`default_nettype wire

### rtl/core/rmq_sqrt_stage.sv
// One digit of the pipelined integer square root.
`default_nettype none
module rmq_sqrt_stage import rmq_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_en,
    input  t_sq       i_sq,
    output t_sq       o_sq
);
    logic [S_W+2:0] rem2, trial;
    logic           ge;
    t_sq            r_sq, n_sq;

    always_comb begin
        rem2  = {i_sq.rem, i_sq.rad[SQ_PAD-1 -: 2]};
        trial = (S_W + 3)'({i_sq.root, 2'b01});
        ge    = (rem2 >= trial);
        n_sq      = i_sq;
        n_sq.rad  = {i_sq.rad[SQ_PAD-3:0], 2'b00};
        n_sq.root = {i_sq.root[S_W-2:0], ge};
        n_sq.rem  = ge ? (S_W + 1)'(rem2 - trial) : (S_W + 1)'(rem2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;
endmodule
`default_nettype wire

### rtl/core/rmq_div_prep.sv
// Main component and rounded dividends from the root.
`default_nettype none
module rmq_div_prep import rmq_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_en,
    input  t_sq       i_sq,
    output t_dv       o_dv
);
    logic [S_W:0] s_p2;
    t_dv          r_dv, n_dv;

    always_comb begin
        s_p2       = (S_W + 1)'(i_sq.root) + (S_W + 1)'(2);
        n_dv.br    = i_sq.side.br;
        n_dv.inv   = i_sq.side.inv;
        n_dv.neg   = i_sq.side.neg;
        n_dv.s     = i_sq.root;
        n_dv.main  = S_W'(s_p2 >> 2);
        for (int k = 0; k < 3; k++) begin
            n_dv.dvd[k] = DIV_W'({i_sq.side.mag[k], FRAC_BITS'(0)})
                        + DIV_W'(i_sq.root >> 1);
            n_dv.rem[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv <= n_dv;
        end
    end

    assign o_dv = r_dv;
endmodule
`default_nettype wire

### rtl/core/rmq_div_stage.sv
// One quotient bit of the three parallel restoring dividers.
`default_nettype none
module rmq_div_stage import rmq_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_en,
    input  t_dv       i_dv,
    output t_dv       o_dv
);
    logic [S_W:0] rem2;
    logic [S_W:0] sx;
    logic         ge;
    t_dv          r_dv, n_dv;

    always_comb begin
        n_dv = i_dv;
        sx   = {1'b0, i_dv.s};
        rem2 = '0;
        ge   = 1'b0;
        for (int k = 0; k < 3; k++) begin
            rem2        = {i_dv.rem[k], i_dv.dvd[k][DIV_W-1]};
            ge          = (rem2 >= sx);
            n_dv.rem[k] = ge ? S_W'(rem2 - sx) : rem2[S_W-1:0];
            n_dv.dvd[k] = {i_dv.dvd[k][DIV_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv <= n_dv;
        end
    end

    assign o_dv = r_dv;
endmodule
`default_nettype wire

### rtl/core/rmq_back.sv
// Sign, saturation and placement of the four quaternion components.
`default_nettype none
module rmq_back import rmq_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  t_dv                     i_dv,
    output logic signed [OUT_W-1:0] o_w,
    output logic signed [OUT_W-1:0] o_x,
    output logic signed [OUT_W-1:0] o_y,
    output logic signed [OUT_W-1:0] o_z,
    output t_branch                 o_br,
    output logic                    o_inv
);
    localparam logic [DIV_W-1:0] POS_LIM = DIV_W'((1 << (OUT_W - 1)) - 1);
    localparam logic [DIV_W-1:0] NEG_LIM = DIV_W'(1 << (OUT_W - 1));
    localparam logic [OUT_W-1:0] OUT_MAX = OUT_W'(POS_LIM);
    localparam logic [OUT_W-1:0] OUT_MIN = OUT_W'(NEG_LIM);

    logic [2:0][OUT_W-1:0] c;
    logic [OUT_W-1:0]      m;
    logic [OUT_W-1:0]      r_w, r_x, r_y, r_z, n_w, n_x, n_y, n_z;
    t_branch               r_br;
    logic                  r_inv;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!i_dv.neg[k]) begin
                c[k] = (i_dv.dvd[k] > POS_LIM) ? OUT_MAX : i_dv.dvd[k][OUT_W-1:0];
            end else begin
                c[k] = (i_dv.dvd[k] > NEG_LIM) ? OUT_MIN
                     : OUT_W'(-i_dv.dvd[k][OUT_W-1:0]);
            end
        end
        m = ((S_W + 1 > OUT_W) && ((S_W + 1)'(i_dv.main) > (S_W + 1)'(POS_LIM)))
          ? OUT_MAX : OUT_W'(i_dv.main);
        unique case (i_dv.br)
            BR_TRACE: begin n_w = m;    n_x = c[0]; n_y = c[1]; n_z = c[2]; end
            BR_X:     begin n_w = c[0]; n_x = m;    n_y = c[1]; n_z = c[2]; end
            BR_Y:     begin n_w = c[0]; n_x = c[1]; n_y = m;    n_z = c[2]; end
            default:  begin n_w = c[0]; n_x = c[1]; n_y = c[2]; n_z = m;    end
        endcase
        if (i_dv.inv) begin
            n_w = '0;
            n_x = '0;
            n_y = '0;
            n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w   <= n_w;
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_br  <= i_dv.br;
            r_inv <= i_dv.inv;
        end
    end

    assign o_w   = r_w;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_br  = r_br;
    assign o_inv = r_inv;
endmodule
`default_nettype wire

### rtl/core/rotation_matrix_to_quaternion.sv
// The pipeline has 52 register stages from request accept to result (1 front,
// 17 root digits, 1 prep, 32 quotient bits, 1 output stage).
// Throughput: one request per cycle while the output is not stalled.
// A stall at the output freezes every stage at once; nothing is dropped.
// Reset (synchronous, active low) clears the valid bits of all stages.
`default_nettype none
module rotation_matrix_to_quaternion import rmq_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic signed [ELEM_W-1:0] i_row0_col0,
    input  wire logic signed [ELEM_W-1:0] i_row0_col1,
    input  wire logic signed [ELEM_W-1:0] i_row0_col2,
    input  wire logic signed [ELEM_W-1:0] i_row1_col0,
    input  wire logic signed [ELEM_W-1:0] i_row1_col1,
    input  wire logic signed [ELEM_W-1:0] i_row1_col2,
    input  wire logic signed [ELEM_W-1:0] i_row2_col0,
    input  wire logic signed [ELEM_W-1:0] i_row2_col1,
    input  wire logic signed [ELEM_W-1:0] i_row2_col2,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic signed [OUT_W-1:0]       o_quat_w,
    output logic signed [OUT_W-1:0]       o_quat_x,
    output logic signed [OUT_W-1:0]       o_quat_y,
    output logic signed [OUT_W-1:0]       o_quat_z,
    output logic [1:0]                    o_branch_taken,
    output logic                          o_invalid
);
    logic              en;
    logic [NSTAGE-1:0] r_vld;
    t_sq               sq_pipe [S_W+1];
    t_dv               dv_pipe [DIV_W+1];
    t_branch           br;

    assign en      = !r_vld[NSTAGE-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NSTAGE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTAGE-2:0], i_valid};
        end
    end

    rmq_front u_front (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a00 (i_row0_col0),
        .i_a01 (i_row0_col1),
        .i_a02 (i_row0_col2),
        .i_a10 (i_row1_col0),
        .i_a11 (i_row1_col1),
        .i_a12 (i_row1_col2),
        .i_a20 (i_row2_col0),
        .i_a21 (i_row2_col1),
        .i_a22 (i_row2_col2),
        .o_sq  (sq_pipe[0])
    );

    for (genvar g = 0; g < S_W; g++) begin : g_sqrt
        rmq_sqrt_stage u_sq (
            .i_clk (i_clk),
            .i_en  (en),
            .i_sq  (sq_pipe[g]),
            .o_sq  (sq_pipe[g+1])
        );
    end

    rmq_div_prep u_prep (
        .i_clk (i_clk),
        .i_en  (en),
        .i_sq  (sq_pipe[S_W]),
        .o_dv  (dv_pipe[0])
    );

    for (genvar g = 0; g < DIV_W; g++) begin : g_div
        rmq_div_stage u_dv (
            .i_clk (i_clk),
            .i_en  (en),
            .i_dv  (dv_pipe[g]),
            .o_dv  (dv_pipe[g+1])
        );
    end

    rmq_back u_back (
        .i_clk (i_clk),
        .i_en  (en),
        .i_dv  (dv_pipe[DIV_W]),
        .o_w   (o_quat_w),
        .o_x   (o_quat_x),
        .o_y   (o_quat_y),
        .o_z   (o_quat_z),
        .o_br  (br),
        .o_inv (o_invalid)
    );

    assign o_branch_taken = br;

    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid |->
            o_quat_w == '0 && o_quat_x == '0 && o_quat_y == '0 && o_quat_z == '0)
        else $error("invalid result with nonzero components");

    a_trace_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_branch_taken == BR_TRACE |-> !o_invalid)
        else $error("trace branch flagged invalid");

    a_trace_w_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_branch_taken == BR_TRACE |-> o_quat_w > 0)
        else $error("trace branch with nonpositive w");
endmodule
`default_nettype wire
